>>> sv/ipbs_pkg.sv
// Package for the interval pixel bin statistics block.
// Holds field widths, register indexes, the bin store word and the sequencer states.
// No dependencies; every other file imports it.
package ipbs_pkg;

	localparam int IPBS_BINS   = 2048;
	localparam int COORD_W     = 32;
	localparam int VALUE_W     = 16;
	localparam int IDX_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int COUNT_W     = 32;
	localparam int SUM_W       = 48;
	localparam int SQ_W        = 64;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_BASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET     = 2'd2;

	localparam logic [COORD_W-1:0] PPB_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [COUNT_W-1:0]        count;
		logic signed [VALUE_W-1:0] max;
		logic signed [VALUE_W-1:0] min;
		logic signed [SUM_W-1:0]   sum;
		logic [SQ_W-1:0]           sq;
	} bin_word_t;

	localparam bin_word_t BIN_EMPTY = '{
		count: '0,
		max:   16'sh8000,
		min:   16'sh7FFF,
		sum:   '0,
		sq:    '0
	};

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL_SQ,
		S_MUL_S,
		S_MUL_E,
		S_RANGE,
		S_WALK,
		S_DRAIN,
		S_READ,
		S_RD_WAIT
	} ipbs_state_t;

endpackage

>>> sv/ipbs_in_if.sv
// Input item channel of the interval pixel bin statistics block.
// Depends on ipbs_pkg for field widths.
interface ipbs_in_if import ipbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [COORD_W-1:0]        interval_start;
	logic [COORD_W-1:0]        interval_end;
	logic signed [VALUE_W-1:0] data_value;
	logic [IDX_W-1:0]          bin_index;

	modport source (output valid, kind, interval_start, interval_end, data_value, bin_index,
		input ready);
	modport sink (input valid, kind, interval_start, interval_end, data_value, bin_index,
		output ready);
endinterface

>>> sv/ipbs_out_if.sv
// Result channel of the interval pixel bin statistics block.
// Depends on ipbs_pkg for field widths.
interface ipbs_out_if import ipbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [COUNT_W-1:0]        bin_count;
	logic signed [VALUE_W-1:0] bin_max;
	logic signed [VALUE_W-1:0] bin_min;
	logic signed [SUM_W-1:0]   bin_sum;
	logic [SQ_W-1:0]           bin_sum_squares;

	modport source (output valid, bin_count, bin_max, bin_min, bin_sum, bin_sum_squares,
		input ready);
	modport sink (input valid, bin_count, bin_max, bin_min, bin_sum, bin_sum_squares,
		output ready);
endinterface

>>> sv/ipbs_cfg_if.sv
// Configuration write channel of the interval pixel bin statistics block.
// Depends on ipbs_pkg for index and data widths.
interface ipbs_cfg_if import ipbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/ipbs_bin_mem.sv
// Bin store: one write port and one registered read port per cycle.
// Depends on ipbs_pkg for the bin word type.
module ipbs_bin_mem import ipbs_pkg::*; #(
	parameter int BINS = IPBS_BINS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(BINS)-1:0]  waddr,
	input  bin_word_t                wdata,
	input  logic                     re,
	input  logic [$clog2(BINS)-1:0]  raddr,
	output bin_word_t                rdata
);

	bin_word_t mem [BINS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/interval_pixel_bin_stats.sv
// Top level of the interval pixel bin statistics block: sequencer, shared multiplier,
// bin update logic and result register. Depends on ipbs_pkg, the three channel
// interfaces and ipbs_bin_mem.
//
//  channel  | modport | payload
//  ---------+---------+-------------------------------------------------------------
//  items    | sink    | kind, interval_start, interval_end, data_value, bin_index
//  results  | source  | bin_count, bin_max, bin_min, bin_sum, bin_sum_squares
//  cfg      | sink    | index, data (always ready)
//
// An accumulate item makes three passes through the one 32x32 multiplier (value square,
// start, end), a range step, one read-modify-write of the bin store per bin in its
// clipped span and a drain step; when that span is empty it ends after the range step.
// A read item waits while the result register stays full.
// After reset a clearing pass writes every bin before items are taken.
// A result waits in its register while the next item is already being worked on.
module interval_pixel_bin_stats import ipbs_pkg::*; #(
	parameter int BINS = IPBS_BINS
) (
	input  logic        clk,
	input  logic        arst_n,
	ipbs_in_if.sink     items,
	ipbs_out_if.source  results,
	ipbs_cfg_if.sink    cfg
);

	localparam int AW = $clog2(BINS);
	localparam logic signed [49:0] LAST = 50'(BINS - 1);

	ipbs_state_t state_q, state_d;

	logic [COORD_W-1:0]        window_start_q;
	logic [COORD_W-1:0]        ppb_q;
	logic [IDX_W-1:0]          zero_offset_q;

	logic [COORD_W-1:0]        start_q;
	logic [COORD_W-1:0]        end_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      neg_s_q;
	logic                      neg_e_q;
	logic [2*COORD_W-1:0]      prod_q;
	logic [2*COORD_W-1:0]      mul_p;
	logic [31:0]               sq_q;
	logic signed [48:0]        x1_q;
	logic [AW-1:0]             cur_q;
	logic [AW-1:0]             hi_q;
	logic [AW-1:0]             wa_q;
	logic                      pend_q;

	logic                      out_valid_q;
	bin_word_t                 out_q;

	logic [COORD_W-1:0]        mul_a;
	logic [COORD_W-1:0]        mul_b;
	logic [16:0]               vabs;
	logic                      neg_cur;
	logic [COORD_W-1:0]        mag_cur;
	logic [COORD_W-1:0]        coord_cur;
	logic signed [48:0]        x2;
	logic signed [48:0]        xm;
	logic signed [49:0]        lo;
	logic signed [49:0]        hi;
	logic signed [49:0]        lo_c;
	logic signed [49:0]        hi_c;
	logic                      idx_ok;
	logic                      out_free;
	logic                      accept;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	bin_word_t                 mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	bin_word_t                 mem_rdata;
	bin_word_t                 upd;

	function automatic logic signed [48:0] to_pixel(input logic [2*COORD_W-1:0] p,
		input logic neg);
		logic signed [48:0] px;
		px = $signed({1'b0, p[63:16]});
		return neg ? -px : px;
	endfunction

	function automatic bin_word_t update_bin(input bin_word_t w,
		input logic signed [VALUE_W-1:0] v, input logic [31:0] sq);
		bin_word_t          r;
		logic signed [48:0] s;
		logic [64:0]        t;
		r.count = (w.count == '1) ? w.count : w.count + 32'd1;
		r.max   = (v > w.max) ? v : w.max;
		r.min   = (v < w.min) ? v : w.min;
		s = $signed({w.sum[47], w.sum}) + $signed({{33{v[15]}}, v});
		if (s[48] != s[47]) begin
			r.sum = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			r.sum = s[47:0];
		end
		t = {1'b0, w.sq} + {33'd0, sq};
		r.sq = t[64] ? '1 : t[63:0];
		return r;
	endfunction

	ipbs_bin_mem #(.BINS(BINS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;
	assign cfg.ready   = 1'b1;
	assign out_free    = !out_valid_q || results.ready;
	assign idx_ok      = ({21'd0, idx_q} < 32'(BINS));

	assign results.valid           = out_valid_q;
	assign results.bin_count       = out_q.count;
	assign results.bin_max         = out_q.max;
	assign results.bin_min         = out_q.min;
	assign results.bin_sum         = out_q.sum;
	assign results.bin_sum_squares = out_q.sq;

	always_comb begin
		vabs      = value_q[15] ? (~{1'b1, value_q} + 17'd1) : {1'b0, value_q};
		coord_cur = (state_q == S_MUL_E) ? end_q : start_q;
		neg_cur   = coord_cur < window_start_q;
		mag_cur   = neg_cur ? (window_start_q - coord_cur) : (coord_cur - window_start_q);
		if (state_q == S_MUL_SQ) begin
			mul_a = {15'd0, vabs};
			mul_b = {15'd0, vabs};
		end else begin
			mul_a = mag_cur;
			mul_b = ppb_q;
		end
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		x2   = to_pixel(prod_q, neg_e_q);
		xm   = (x2 > x1_q) ? x2 : x1_q;
		lo   = $signed({39'd0, zero_offset_q}) + $signed({x1_q[48], x1_q});
		hi   = $signed({39'd0, zero_offset_q}) + $signed({xm[48], xm});
		lo_c = (lo < 0) ? 50'sd0 : lo;
		hi_c = (hi > LAST) ? LAST : hi;
	end

	assign upd = update_bin(mem_rdata, value_q, sq_q);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = BIN_EMPTY;
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				if (cur_q == AW'(BINS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = items.kind ? S_READ : S_MUL_SQ;
				end
			end
			S_MUL_SQ: state_d = S_MUL_S;
			S_MUL_S:  state_d = S_MUL_E;
			S_MUL_E:  state_d = S_RANGE;
			S_RANGE: begin
				state_d = (lo_c > hi_c) ? S_IDLE : S_WALK;
			end
			S_WALK: begin
				mem_re    = 1'b1;
				mem_we    = pend_q;
				mem_wdata = upd;
				if (cur_q == hi_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				mem_we    = pend_q;
				mem_wdata = upd;
				state_d   = S_IDLE;
			end
			S_READ: begin
				mem_re    = idx_ok;
				mem_raddr = AW'(idx_q);
				state_d   = S_RD_WAIT;
			end
			S_RD_WAIT: begin
				mem_waddr = AW'(idx_q);
				if (out_free) begin
					mem_we  = idx_ok;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			ppb_q          <= PPB_RESET;
			zero_offset_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_WINDOW_START:    window_start_q <= cfg.data;
				REG_PIXELS_PER_BASE: ppb_q          <= cfg.data;
				REG_ZERO_OFFSET:     zero_offset_q  <= cfg.data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= (state_q == S_WALK);
			if (state_q == S_CLEAR || state_q == S_WALK) begin
				cur_q <= cur_q + AW'(1);
			end else if (state_q == S_RANGE) begin
				cur_q <= AW'(lo_c);
			end
			if (state_q == S_RD_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= items.interval_start;
			end_q   <= items.interval_end;
			value_q <= items.data_value;
			idx_q   <= items.bin_index;
		end
		if (state_q == S_MUL_SQ || state_q == S_MUL_S || state_q == S_MUL_E) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MUL_S) begin
			sq_q    <= prod_q[31:0];
			neg_s_q <= neg_cur;
		end
		if (state_q == S_MUL_E) begin
			neg_e_q <= neg_cur;
			x1_q    <= to_pixel(prod_q, neg_s_q);
		end
		if (state_q == S_RANGE) begin
			hi_q <= AW'(hi_c);
		end
		if (state_q == S_WALK) begin
			wa_q <= cur_q;
		end
		if (state_q == S_RD_WAIT && out_free) begin
			out_q <= idx_ok ? mem_rdata : BIN_EMPTY;
		end
	end

`ifndef SYNTHESIS
	a_walk_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> cur_q <= hi_q)
		else $error("bin walk ran past the end of its span");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("bin store written while the sequencer is idle");

	a_clear_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !items.ready)
		else $error("item channel ready during the clearing pass");

	a_drain_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> pend_q && wa_q == hi_q)
		else $error("last bin of a walk not written back");
`endif

endmodule
